>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; they compile to nothing when SYNTH is set.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> rtl/plf_pkg.sv
// ---------------------------------------------------------------------------
// Playfair package
// Shared constants, register codes and the configuration bundle.
// ---------------------------------------------------------------------------
package plf_pkg;

    localparam int SIDE       = 5;
    localparam int LETTER_W   = 5;
    localparam int CODE_W     = 7;
    localparam int CHAR_W     = 8;
    localparam int CFG_DATA_W = 50;
    localparam int CFG_IDX_W  = 3;
    localparam int POS_W      = 3;

    localparam logic [LETTER_W-1:0] LETTER_I     = 5'd8;
    localparam logic [LETTER_W-1:0] LETTER_J     = 5'd9;
    localparam logic [LETTER_W-1:0] FILLER_RESET = 5'd23;
    localparam logic [CODE_W-1:0]   ASCII_A      = 7'd65;

    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'd65;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'd90;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'd97;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'd122;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DECRYPT_MODE  = 3'd0,
        CFG_FILLER_LETTER = 3'd1,
        CFG_CELLS_LOW     = 3'd2,
        CFG_CELLS_MID     = 3'd3,
        CFG_CELLS_HIGH    = 3'd4
    } cfg_index_t;

    // square[row][col] holds the letter index of cell row*5+col; the packed
    // layout matches the concatenation of the high, mid and low registers.
    typedef logic [SIDE-1:0][SIDE-1:0][LETTER_W-1:0] square_t;

    typedef struct packed {
        logic                decrypt_mode;
        logic [LETTER_W-1:0] filler_letter;
        square_t             square;
    } cfg_t;

    function automatic logic [LETTER_W-1:0] fold_j(input logic [LETTER_W-1:0] letter);
        return (letter == LETTER_J) ? LETTER_I : letter;
    endfunction

endpackage

>>> rtl/playfair_digraph_cipher.sv
// ---------------------------------------------------------------------------
// Playfair digraph cipher
// Filters a byte stream to letters, pairs them and enciphers each pair.
// ---------------------------------------------------------------------------
// Each pair passes the byte register, then the pair register; the lookup and cell
// select finish in one stage. One byte per cycle unless the pair output stalls.
// Bytes that are not letters, and the first letter of a pair, give no output.
// Reset clears the held letter and the valid flags of both pipeline registers, and
// sets the configuration to encrypt mode, filler X and an all-zero square.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module playfair_digraph_cipher
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               text_valid,
    output logic                               text_stall,
    input  logic [plf_pkg::CHAR_W-1:0]         char_in,
    output logic                               pair_valid,
    input  logic                               pair_stall,
    output logic [plf_pkg::CODE_W-1:0]         first_out,
    output logic [plf_pkg::CODE_W-1:0]         second_out,
    output logic                               filler_used,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [plf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [plf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    plf_pkg::cfg_t cfg;

    logic                          char_valid_reg, char_valid_next;
    logic [plf_pkg::CHAR_W-1:0]    char_reg;
    logic                          held_valid_reg, held_valid_next;
    logic [plf_pkg::LETTER_W-1:0]  held_letter_reg, held_letter_next;
    logic                          pair_valid_reg, pair_valid_next;
    logic [plf_pkg::CODE_W-1:0]    first_reg, second_reg;
    logic                          filler_reg;

    logic                          is_upper, is_lower, is_letter;
    logic [plf_pkg::CHAR_W-1:0]    char_off;
    logic [plf_pkg::LETTER_W-1:0]  letter;
    logic                          doubled, makes_pair, fire;
    logic [plf_pkg::LETTER_W-1:0]  partner;
    logic [plf_pkg::CODE_W-1:0]    first_code, second_code;

    assign cfg_ready = 1'b1;

    plf_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Letter filter on the registered byte.
    always_comb
    begin
        is_upper  = (char_reg >= plf_pkg::CHAR_UPPER_A) && (char_reg <= plf_pkg::CHAR_UPPER_Z);
        is_lower  = (char_reg >= plf_pkg::CHAR_LOWER_A) && (char_reg <= plf_pkg::CHAR_LOWER_Z);
        is_letter = is_upper || is_lower;
        char_off  = char_reg - (is_upper ? plf_pkg::CHAR_UPPER_A : plf_pkg::CHAR_LOWER_A);
        letter    = plf_pkg::fold_j(char_off[plf_pkg::LETTER_W-1:0]);
    end

    // A doubled pair only inserts the filler in encrypt mode.
    assign makes_pair = is_letter && held_valid_reg;
    assign doubled    = !cfg.decrypt_mode && (held_letter_reg == letter);
    assign partner    = doubled ? plf_pkg::fold_j(cfg.filler_letter) : letter;

    plf_xform u_xform
    (
        .cfg           (cfg),
        .first_letter  (held_letter_reg),
        .second_letter (partner),
        .first_code    (first_code),
        .second_code   (second_code)
    );

    // The registered byte retires unless it makes a pair and the output is full.
    assign fire       = char_valid_reg && (!makes_pair || !pair_valid_reg || !pair_stall);
    assign text_stall = char_valid_reg && !fire;

    always_comb
    begin
        char_valid_next  = text_valid ? 1'b1 : (char_valid_reg && !fire);
        held_valid_next  = held_valid_reg;
        held_letter_next = held_letter_reg;
        if (fire && is_letter)
        begin
            if (!held_valid_reg)
            begin
                held_valid_next  = 1'b1;
                held_letter_next = letter;
            end
            else if (doubled)
            begin
                // The repeated letter opens the next pair.
                held_valid_next  = 1'b1;
                held_letter_next = letter;
            end
            else
            begin
                held_valid_next  = 1'b0;
                held_letter_next = '0;
            end
        end

        if (fire && makes_pair)
        begin
            pair_valid_next = 1'b1;
        end
        else if (!pair_stall)
        begin
            pair_valid_next = 1'b0;
        end
        else
        begin
            pair_valid_next = pair_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_valid_reg  <= 1'b0;
            held_valid_reg  <= 1'b0;
            held_letter_reg <= '0;
            pair_valid_reg  <= 1'b0;
        end
        else
        begin
            char_valid_reg  <= char_valid_next;
            held_valid_reg  <= held_valid_next;
            held_letter_reg <= held_letter_next;
            pair_valid_reg  <= pair_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!text_stall)
        begin
            char_reg <= char_in;
        end
        if (fire && makes_pair)
        begin
            first_reg  <= first_code;
            second_reg <= second_code;
            filler_reg <= doubled;
        end
    end

    assign pair_valid  = pair_valid_reg;
    assign first_out   = first_reg;
    assign second_out  = second_reg;
    assign filler_used = filler_reg;

    `ASSERT_IMPLY(a_stall_needs_byte, clk, rst_n, text_stall, char_valid_reg, "stall, no byte")
    `ASSERT_IMPLY(a_pair_needs_held, clk, rst_n, $rose(pair_valid), $past(held_valid_reg), "no held")
    `ASSERT_IMPLY(a_filler_encrypt_only, clk, rst_n, pair_valid && filler_used, !cfg.decrypt_mode, "fill")
    `ASSERT_NEXT(a_double_keeps_held, clk, rst_n, fire && makes_pair && doubled, held_valid_reg, "held")

endmodule

>>> rtl/plf_cfg.sv
// ---------------------------------------------------------------------------
// Playfair configuration registers
// Holds the mode, the filler letter and the 5x5 square written by software.
// ---------------------------------------------------------------------------
module plf_cfg
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [plf_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [plf_pkg::CFG_DATA_W-1:0]     wr_data,
    output plf_pkg::cfg_t                      cfg
);

    logic                              decrypt_reg;
    logic [plf_pkg::LETTER_W-1:0]      filler_reg;
    logic [49:0]                       cells_low_reg;
    logic [49:0]                       cells_mid_reg;
    logic [24:0]                       cells_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decrypt_reg    <= 1'b0;
            filler_reg     <= plf_pkg::FILLER_RESET;
            cells_low_reg  <= '0;
            cells_mid_reg  <= '0;
            cells_high_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                plf_pkg::CFG_DECRYPT_MODE:  decrypt_reg    <= wr_data[0];
                plf_pkg::CFG_FILLER_LETTER: filler_reg     <= wr_data[4:0];
                plf_pkg::CFG_CELLS_LOW:     cells_low_reg  <= wr_data[49:0];
                plf_pkg::CFG_CELLS_MID:     cells_mid_reg  <= wr_data[49:0];
                plf_pkg::CFG_CELLS_HIGH:    cells_high_reg <= wr_data[24:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.decrypt_mode  = decrypt_reg;
    assign cfg.filler_letter = filler_reg;
    assign cfg.square        = {cells_high_reg, cells_mid_reg, cells_low_reg};

endmodule

>>> rtl/plf_xform.sv
// ---------------------------------------------------------------------------
// Playfair pair transform
// Locates both letters in the square and picks the two cipher cells.
// ---------------------------------------------------------------------------
module plf_xform
(
    input  plf_pkg::cfg_t                      cfg,
    input  logic [plf_pkg::LETTER_W-1:0]       first_letter,
    input  logic [plf_pkg::LETTER_W-1:0]       second_letter,
    output logic [plf_pkg::CODE_W-1:0]         first_code,
    output logic [plf_pkg::CODE_W-1:0]         second_code
);

    localparam logic [plf_pkg::POS_W-1:0] LAST = plf_pkg::POS_W'(plf_pkg::SIDE - 1);

    // Priority match: the lowest matching cell wins, and no match gives cell 0.
    function automatic logic [2*plf_pkg::POS_W-1:0] locate(
        input plf_pkg::square_t            sq,
        input logic [plf_pkg::LETTER_W-1:0] letter
    );
        logic [2*plf_pkg::POS_W-1:0] pos;
        pos = '0;
        for (int r = plf_pkg::SIDE - 1; r >= 0; r--)
        begin
            for (int c = plf_pkg::SIDE - 1; c >= 0; c--)
            begin
                if (sq[r][c] == letter)
                begin
                    pos = {r[plf_pkg::POS_W-1:0], c[plf_pkg::POS_W-1:0]};
                end
            end
        end
        return pos;
    endfunction

    function automatic logic [plf_pkg::POS_W-1:0] shift(
        input logic [plf_pkg::POS_W-1:0] x,
        input logic                      back
    );
        logic [plf_pkg::POS_W-1:0] y;
        if (back)
        begin
            y = (x == '0) ? LAST : x - 1'b1;
        end
        else
        begin
            y = (x == LAST) ? '0 : x + 1'b1;
        end
        return y;
    endfunction

    logic [plf_pkg::POS_W-1:0]    ra, ca, rb, cb;
    logic [plf_pkg::POS_W-1:0]    oa_row, oa_col, ob_row, ob_col;
    logic [plf_pkg::LETTER_W-1:0] cell_a, cell_b;

    always_comb
    begin
        {ra, ca} = locate(cfg.square, first_letter);
        {rb, cb} = locate(cfg.square, second_letter);

        if (ra == rb)
        begin
            oa_row = ra;
            oa_col = shift(ca, cfg.decrypt_mode);
            ob_row = rb;
            ob_col = shift(cb, cfg.decrypt_mode);
        end
        else if (ca == cb)
        begin
            oa_row = shift(ra, cfg.decrypt_mode);
            oa_col = ca;
            ob_row = shift(rb, cfg.decrypt_mode);
            ob_col = cb;
        end
        else
        begin
            oa_row = ra;
            oa_col = cb;
            ob_row = rb;
            ob_col = ca;
        end

        cell_a = cfg.square[oa_row][oa_col];
        cell_b = cfg.square[ob_row][ob_col];
    end

    assign first_code  = {2'b00, cell_a} + plf_pkg::ASCII_A;
    assign second_code = {2'b00, cell_b} + plf_pkg::ASCII_A;

endmodule

>>> verif/tb.sv
// ---------------------------------------------------------------------------
// Playfair digraph cipher testbench
// Drives filtered and raw text bytes through the cipher under several square,
// filler and mode settings, predicts every enciphered pair and checks each
// output word against it in order, with random idling on both channels.
// ---------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [plf_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int CELL_COUNT = plf_pkg::SIDE * plf_pkg::SIDE;
    localparam int HOLD_CYCLES = 80;

    typedef struct packed {
        logic [plf_pkg::CODE_W-1:0] first_code;
        logic [plf_pkg::CODE_W-1:0] second_code;
        logic                       filler;
    } pair_t;

    logic                           clk;
    logic                           rst_n;
    logic                           text_valid;
    logic                           text_stall;
    logic [plf_pkg::CHAR_W-1:0]     char_in;
    logic                           pair_valid;
    logic                           pair_stall;
    logic [plf_pkg::CODE_W-1:0]     first_out;
    logic [plf_pkg::CODE_W-1:0]     second_out;
    logic                           filler_used;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [plf_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [plf_pkg::CFG_DATA_W-1:0] cfg_data;

    // Predictor copy of the configuration and the pairing state.
    logic                         dec_mode;
    logic [plf_pkg::LETTER_W-1:0] fill_letter;
    logic [plf_pkg::LETTER_W-1:0] key_sq [CELL_COUNT];
    logic [plf_pkg::LETTER_W-1:0] held;
    logic                         held_ok;

    pair_t pending_pairs [$];
    pair_t exp_pair;
    int    errors;

    bit send_idle;
    bit recv_idle;
    bit hold_req;

    playfair_digraph_cipher dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_valid  (text_valid),
        .text_stall  (text_stall),
        .char_in     (char_in),
        .pair_valid  (pair_valid),
        .pair_stall  (pair_stall),
        .first_out   (first_out),
        .second_out  (second_out),
        .filler_used (filler_used),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic logic [plf_pkg::CFG_DATA_W-1:0] rand_data();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[plf_pkg::CFG_DATA_W-1:0];
    endfunction

    function automatic int pick_gap(bit enable);
        int r;
        if (!enable)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic bit is_letter(logic [plf_pkg::CHAR_W-1:0] ch);
        return (ch >= plf_pkg::CHAR_UPPER_A && ch <= plf_pkg::CHAR_UPPER_Z) ||
               (ch >= plf_pkg::CHAR_LOWER_A && ch <= plf_pkg::CHAR_LOWER_Z);
    endfunction

    function automatic void reset_predictor();
        dec_mode    = 1'b0;
        fill_letter = plf_pkg::FILLER_RESET;
        foreach (key_sq[n])
            key_sq[n] = '0;
        held    = '0;
        held_ok = 1'b0;
    endfunction

    function automatic void apply_cfg(logic [plf_pkg::CFG_IDX_W-1:0] idx,
                                      logic [plf_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            plf_pkg::CFG_DECRYPT_MODE:  dec_mode = data[0];
            plf_pkg::CFG_FILLER_LETTER: fill_letter = data[plf_pkg::LETTER_W-1:0];
            plf_pkg::CFG_CELLS_LOW:
                for (int n = 0; n < 10; n++) key_sq[n] = data[5*n +: 5];
            plf_pkg::CFG_CELLS_MID:
                for (int n = 0; n < 10; n++) key_sq[10+n] = data[5*n +: 5];
            plf_pkg::CFG_CELLS_HIGH:
                for (int n = 0; n < 5; n++) key_sq[20+n] = data[5*n +: 5];
            default: ;
        endcase
    endfunction

    // Lowest cell holding the letter wins; with no match the corner cell is used.
    function automatic int find_pos(logic [plf_pkg::LETTER_W-1:0] letter);
        for (int n = 0; n < CELL_COUNT; n++)
            if (key_sq[n] == letter)
                return n;
        return 0;
    endfunction

    function automatic pair_t encipher(logic [plf_pkg::LETTER_W-1:0] a,
                                       logic [plf_pkg::LETTER_W-1:0] b,
                                       logic used);
        int pa, pb, ra, ca, rb, cb, step, oa, ob;
        pair_t p;
        pa = find_pos(a);
        pb = find_pos(b);
        ra = pa / plf_pkg::SIDE;
        ca = pa % plf_pkg::SIDE;
        rb = pb / plf_pkg::SIDE;
        cb = pb % plf_pkg::SIDE;
        // Moving back one place is the same as moving forward four.
        step = dec_mode ? plf_pkg::SIDE - 1 : 1;
        if (ra == rb)
        begin
            oa = ra * plf_pkg::SIDE + (ca + step) % plf_pkg::SIDE;
            ob = rb * plf_pkg::SIDE + (cb + step) % plf_pkg::SIDE;
        end
        else if (ca == cb)
        begin
            oa = ((ra + step) % plf_pkg::SIDE) * plf_pkg::SIDE + ca;
            ob = ((rb + step) % plf_pkg::SIDE) * plf_pkg::SIDE + cb;
        end
        else
        begin
            oa = ra * plf_pkg::SIDE + cb;
            ob = rb * plf_pkg::SIDE + ca;
        end
        p.first_code  = {2'b00, key_sq[oa]} + plf_pkg::ASCII_A;
        p.second_code = {2'b00, key_sq[ob]} + plf_pkg::ASCII_A;
        p.filler      = used;
        return p;
    endfunction

    function automatic void predict_byte(logic [plf_pkg::CHAR_W-1:0] ch);
        logic [plf_pkg::LETTER_W-1:0] letter;
        logic [plf_pkg::LETTER_W-1:0] fill;
        if (!is_letter(ch))
            return;
        // Both cases carry the letter number plus one in their low five bits.
        letter = ch[4:0] - 5'd1;
        if (letter == plf_pkg::LETTER_J)
            letter = plf_pkg::LETTER_I;
        fill = (fill_letter == plf_pkg::LETTER_J) ? plf_pkg::LETTER_I : fill_letter;
        if (!held_ok)
        begin
            held    = letter;
            held_ok = 1'b1;
            return;
        end
        if (!dec_mode && held == letter)
        begin
            pending_pairs.push_back(encipher(held, fill, 1'b1));
            held = letter;
            return;
        end
        pending_pairs.push_back(encipher(held, letter, 1'b0));
        held    = '0;
        held_ok = 1'b0;
    endfunction

    task automatic report(input string name, input logic [plf_pkg::CODE_W-1:0] want,
                          input logic [plf_pkg::CODE_W-1:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Output words are checked before the byte taken at the same edge is predicted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pair_valid && !pair_stall)
            begin
                if (pending_pairs.size() == 0)
                begin
                    errors++;
                    $display("%0t: pair expected none, actual %0d %0d %0d", $time,
                             first_out, second_out, filler_used);
                end
                else
                begin
                    exp_pair = pending_pairs.pop_front();
                    report("first_out", exp_pair.first_code, first_out);
                    report("second_out", exp_pair.second_code, second_out);
                    report("filler_used", {6'd0, exp_pair.filler}, {6'd0, filler_used});
                end
            end
            if (text_valid && !text_stall)
                predict_byte(char_in);
        end
    end

    // Receiver side: random stalls, or one long hold-off when requested.
    initial
    begin
        int n;
        pair_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                pair_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                pair_stall <= 1'b0;
            end
            else
            begin
                n = pick_gap(recv_idle);
                if (n > 0)
                begin
                    pair_stall <= 1'b1;
                    repeat (n) @(negedge clk);
                end
                pair_stall <= 1'b0;
            end
        end
    end

    // Called at a falling edge; returns at a falling edge with nothing scheduled there.
    task automatic send_char(input logic [plf_pkg::CHAR_W-1:0] c);
        int gap;
        text_valid <= 1'b1;
        char_in    <= c;
        do @(posedge clk); while (text_stall);
        @(negedge clk);
        gap = pick_gap(send_idle);
        if (gap > 0)
        begin
            text_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    // Waits until every pair is out and the pipeline has drained.
    task automatic settle();
        text_valid <= 1'b0;
        wait (pending_pairs.size() == 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [plf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [plf_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        apply_cfg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic write_square(input logic [plf_pkg::LETTER_W-1:0] s [CELL_COUNT]);
        logic [plf_pkg::CFG_DATA_W-1:0] lo, mi, hi;
        hi = rand_data();
        for (int n = 0; n < 10; n++)
        begin
            lo[5*n +: 5] = s[n];
            mi[5*n +: 5] = s[10+n];
        end
        for (int n = 0; n < 5; n++)
            hi[5*n +: 5] = s[20+n];
        cfg_write(plf_pkg::CFG_CELLS_LOW, lo);
        cfg_write(plf_pkg::CFG_CELLS_MID, mi);
        cfg_write(plf_pkg::CFG_CELLS_HIGH, hi);
    endtask

    // Alphabet without J, in order or shuffled.
    task automatic make_square(output logic [plf_pkg::LETTER_W-1:0] s [CELL_COUNT],
                               input bit shuffle);
        int k, j;
        logic [plf_pkg::LETTER_W-1:0] t;
        k = 0;
        for (int l = 0; l < 26; l++)
            if (l != plf_pkg::LETTER_J)
            begin
                s[k] = plf_pkg::LETTER_W'(l);
                k++;
            end
        if (shuffle)
            for (int i = CELL_COUNT - 1; i > 0; i--)
            begin
                j    = $urandom_range(0, i);
                t    = s[i];
                s[i] = s[j];
                s[j] = t;
            end
    endtask

    task automatic set_mode(input logic mode);
        logic [plf_pkg::CFG_DATA_W-1:0] d;
        d = rand_data();
        d[0] = mode;
        cfg_write(plf_pkg::CFG_DECRYPT_MODE, d);
    endtask

    task automatic set_filler(input logic [plf_pkg::LETTER_W-1:0] fill);
        logic [plf_pkg::CFG_DATA_W-1:0] d;
        d = rand_data();
        d[plf_pkg::LETTER_W-1:0] = fill;
        cfg_write(plf_pkg::CFG_FILLER_LETTER, d);
    endtask

    task automatic random_stream(input int letters);
        int sent, r;
        logic [plf_pkg::CHAR_W-1:0] c, last;
        sent = 0;
        last = plf_pkg::CHAR_UPPER_A;
        while (sent < letters)
        begin
            r = $urandom_range(0, 99);
            if (r < 22)
                c = plf_pkg::CHAR_W'($urandom_range(0, 255));
            else if (r < 42)
                c = last ^ (plf_pkg::CHAR_W'($urandom_range(0, 1)) << 5);
            else
                c = ($urandom_range(0, 1) ? plf_pkg::CHAR_UPPER_A : plf_pkg::CHAR_LOWER_A)
                    + plf_pkg::CHAR_W'($urandom_range(0, 25));
            if (is_letter(c))
            begin
                sent++;
                last = c;
            end
            send_char(c);
        end
    endtask

    // With the all-zero square every letter lands on the corner cell.
    task automatic test_reset_square();
        send_text("aB");
        settle();
    endtask

    task automatic test_basic_rules();
        logic [plf_pkg::LETTER_W-1:0] s [CELL_COUNT];
        make_square(s, 1'b0);
        write_square(s);
        send_text("Az@[`{");
        send_char(8'h00);
        send_char(8'hFF);
        // A doubled I from j and I, then row and column pairs.
        send_text("jIkdT");
        settle();
    endtask

    task automatic test_filler_letters();
        send_text("XXe");
        settle();
        set_filler(plf_pkg::LETTER_J);
        send_text("IIm");
        settle();
        set_filler(5'd31);
        send_text("KKq");
        settle();
    endtask

    // Doubled letters pass as plain pairs; the trailing Q stays held.
    task automatic test_decrypt_pairs();
        set_mode(1'b1);
        send_text("EEQ");
        settle();
        set_mode(1'b0);
    endtask

    task automatic test_odd_square();
        set_filler(plf_pkg::FILLER_RESET);
        cfg_write(plf_pkg::CFG_CELLS_LOW, rand_data());
        cfg_write(plf_pkg::CFG_CELLS_MID, rand_data());
        cfg_write(plf_pkg::CFG_CELLS_HIGH, rand_data());
        cfg_write(CFG_UNUSED, rand_data());
        send_text("MNab");
        settle();
    endtask

    task automatic test_random_settings();
        logic [plf_pkg::LETTER_W-1:0] s [CELL_COUNT];
        for (int p = 0; p < 7; p++)
        begin
            send_idle = (p != 3);
            recv_idle = (p != 4);
            set_mode(p == 0 ? 1'b0 : (p == 1 ? 1'b1 : 1'($urandom_range(0, 1))));
            set_filler(p == 0 ? 5'd0 : (p == 1 ? 5'd25 : 5'($urandom_range(0, 31))));
            if (p == 5)
            begin
                cfg_write(plf_pkg::CFG_CELLS_LOW, rand_data());
                cfg_write(plf_pkg::CFG_CELLS_MID, rand_data());
                cfg_write(plf_pkg::CFG_CELLS_HIGH, rand_data());
            end
            else if (p == 6)
            begin
                cfg_write(plf_pkg::CFG_CELLS_LOW, '1);
                cfg_write(plf_pkg::CFG_CELLS_MID, '1);
                cfg_write(plf_pkg::CFG_CELLS_HIGH, '1);
            end
            else
            begin
                make_square(s, 1'b1);
                write_square(s);
            end
            random_stream(45);
            settle();
        end
        send_idle = 1'b1;
        recv_idle = 1'b1;
    endtask

    // The receiver holds off while bytes keep coming, so the input backs up.
    task automatic test_backpressure();
        logic [plf_pkg::LETTER_W-1:0] s [CELL_COUNT];
        set_mode(1'b0);
        make_square(s, 1'b1);
        write_square(s);
        send_idle = 1'b0;
        hold_req  = 1'b1;
        random_stream(40);
        settle();
        send_idle = 1'b1;
    endtask

    initial
    begin
        rst_n      = 1'b0;
        text_valid = 1'b0;
        char_in    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = plf_pkg::CFG_DECRYPT_MODE;
        cfg_data   = '0;
        send_idle  = 1'b1;
        recv_idle  = 1'b1;
        hold_req   = 1'b0;
        errors     = 0;
        reset_predictor();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_square();
        test_basic_rules();
        test_filler_letters();
        test_decrypt_pairs();
        test_odd_square();
        test_random_settings();
        test_backpressure();

        settle();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
